[hdl/i2cbs_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
// Used by i2cbs_ucode_rom and i2c_master_bit_sequencer; no dependencies.
package i2cbs_pkg;

  localparam int unsigned PcWidth  = 5;
  localparam int unsigned CntWidth = 3;

  typedef logic [PcWidth-1:0] pc_t;

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ      = 3'd3,
    CMD_SEND_ACK  = 3'd4,
    CMD_RECV_ACK  = 3'd5,
    CMD_RSVD6     = 3'd6,
    CMD_RSVD7     = 3'd7
  } cmd_t;

  // Which line a step writes.
  typedef enum logic {
    PIN_SCL = 1'b0,
    PIN_SDA = 1'b1
  } pin_t;

  // Where the written level comes from.
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ONE  = 2'd1,
    SRC_DATA = 2'd2,
    SRC_ACK  = 2'd3
  } src_t;

  // One microcode word.
  typedef struct packed {
    pin_t pin;
    src_t src;
    logic fin;     // unconditional end of program
    logic loop;    // jump to target until the bit counter wraps, else end
    pc_t  target;
    logic rd;      // present the sampled byte on the final beat
    logic ak;      // present the sampled ack on the final beat
  } uword_t;

  // Program entry points.
  localparam pc_t EntryStart   = 5'd0;
  localparam pc_t EntryStop    = 5'd4;
  localparam pc_t EntryWrite   = 5'd7;
  localparam pc_t EntryRead    = 5'd10;
  localparam pc_t EntryReadBit = 5'd11;
  localparam pc_t EntrySendAck = 5'd13;
  localparam pc_t EntryRecvAck = 5'd16;
  localparam pc_t LastAddr     = 5'd18;

  localparam logic [7:0] TopBit = 8'h80;

  typedef struct packed {
    logic ok;
    pc_t  pc;
  } entry_t;

  function automatic entry_t cmd_entry(input logic [2:0] cmd);
    entry_t e;
    e.ok = 1'b1;
    e.pc = EntryStart;
    unique case (cmd_t'(cmd))
      CMD_START:    e.pc = EntryStart;
      CMD_STOP:     e.pc = EntryStop;
      CMD_WRITE:    e.pc = EntryWrite;
      CMD_READ:     e.pc = EntryRead;
      CMD_SEND_ACK: e.pc = EntrySendAck;
      CMD_RECV_ACK: e.pc = EntryRecvAck;
      default:      e.ok = 1'b0;
    endcase
    return e;
  endfunction

endpackage

[hdl/i2cbs_ucode_rom.sv]
// Microcode store for the I2C master bit sequencer: one control word per step.
// Depends on i2cbs_pkg for the word layout and entry points.
module i2cbs_ucode_rom (
  input  i2cbs_pkg::pc_t    pc,
  output i2cbs_pkg::uword_t word
);

  localparam i2cbs_pkg::pc_t NoJump = '0;

  function automatic i2cbs_pkg::uword_t uw(input i2cbs_pkg::pin_t pin,
                                           input i2cbs_pkg::src_t src,
                                           input logic fin, input logic loop,
                                           input i2cbs_pkg::pc_t target,
                                           input logic rd, input logic ak);
    i2cbs_pkg::uword_t w;
    w.pin    = pin;
    w.src    = src;
    w.fin    = fin;
    w.loop   = loop;
    w.target = target;
    w.rd     = rd;
    w.ak     = ak;
    return w;
  endfunction

  always_comb begin
    unique case (pc)
      // start
      5'd0:  word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd1:  word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd2:  word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_ZERO, 1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd3:  word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ZERO, 1'b1, 1'b0, NoJump, 1'b0, 1'b0);
      // stop
      5'd4:  word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_ZERO, 1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd5:  word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd6:  word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_ONE,  1'b1, 1'b0, NoJump, 1'b0, 1'b0);
      // write byte: eight passes of set data, clock high, clock low
      5'd7:  word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_DATA, 1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd8:  word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd9:  word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ZERO, 1'b0, 1'b1,
                       i2cbs_pkg::EntryWrite, 1'b0, 1'b0);
      // read byte: release data, then a clock pulse for each bit
      5'd10: word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd11: word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd12: word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ZERO, 1'b0, 1'b1,
                       i2cbs_pkg::EntryReadBit, 1'b1, 1'b0);
      // send ack
      5'd13: word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_ACK,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd14: word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd15: word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ZERO, 1'b1, 1'b0, NoJump, 1'b0, 1'b0);
      // receive ack
      5'd16: word = uw(i2cbs_pkg::PIN_SDA, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd17: word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ONE,  1'b0, 1'b0, NoJump, 1'b0, 1'b0);
      5'd18: word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ZERO, 1'b1, 1'b0, NoJump, 1'b0, 1'b1);
      // unused addresses end the program with the clock low
      default: word = uw(i2cbs_pkg::PIN_SCL, i2cbs_pkg::SRC_ZERO, 1'b1, 1'b0, NoJump, 1'b0, 1'b0);
    endcase
  end

endmodule

[hdl/i2c_master_bit_sequencer.sv]
// Byte-level I2C master: one command beat in, one beat out per SCL/SDA pin write.
// Start gives 4 beats, stop 3, write byte 24, read byte 17, send ack 3,
// receive ack 3; codes 6 and 7 are taken and give nothing. A command walks a
// microcode program at one step per cycle while the output is not stalled. A
// new command is taken once the previous one has launched its final beat,
// even while that beat still waits in the output register. Line levels hold
// between commands; both rise after reset.
// Depends on i2cbs_pkg and i2cbs_ucode_rom.
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] write_byte,
  input  logic       ack_bit,
  input  logic [7:0] bus_sda_bits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl,
  output logic       sda,
  output logic [7:0] read_byte,
  output logic       ack_in,
  output logic       last
);

  logic                                busy;
  i2cbs_pkg::pc_t                      pc;
  logic [i2cbs_pkg::CntWidth-1:0]      cnt;
  logic [7:0]                          shift;
  logic [7:0]                          sampled;
  logic                                ack;
  logic                                scl_level;
  logic                                sda_level;

  i2cbs_pkg::uword_t                   word;
  i2cbs_pkg::entry_t                   entry;
  logic                                accept;
  logic                                adv;
  logic                                cnt_done;
  logic                                step_last;
  logic                                level;
  logic                                scl_next;
  logic                                sda_next;

  i2cbs_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign entry     = i2cbs_pkg::cmd_entry(command);
  assign adv       = busy && (!out_valid || !out_stall);
  assign cnt_done  = (cnt == {i2cbs_pkg::CntWidth{1'b1}});
  assign step_last = word.fin || (word.loop && cnt_done);

  always_comb begin
    unique case (word.src)
      i2cbs_pkg::SRC_ZERO: level = 1'b0;
      i2cbs_pkg::SRC_ONE:  level = 1'b1;
      i2cbs_pkg::SRC_DATA: level = |(shift & i2cbs_pkg::TopBit);
      i2cbs_pkg::SRC_ACK:  level = ack;
      default:             level = 1'b0;
    endcase
    scl_next = scl_level;
    sda_next = sda_level;
    if (word.pin == i2cbs_pkg::PIN_SCL) begin
      scl_next = level;
    end else begin
      sda_next = level;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      cnt       <= '0;
      scl_level <= 1'b1;
      sda_level <= 1'b1;
    end else if (accept) begin
      busy <= entry.ok;
      pc   <= entry.pc;
      cnt  <= '0;
    end else if (adv) begin
      scl_level <= scl_next;
      sda_level <= sda_next;
      if (step_last) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else if (word.loop) begin
        pc  <= word.target;
        cnt <= cnt + 1'b1;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  // command operands
  always_ff @(posedge clk) begin
    if (accept) begin
      shift   <= write_byte;
      sampled <= bus_sda_bits;
      ack     <= ack_bit;
    end else if (adv && word.loop && !cnt_done) begin
      shift <= {shift[6:0], 1'b0};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scl       <= scl_next;
      sda       <= sda_next;
      last      <= step_last;
      read_byte <= (step_last && word.rd) ? sampled : 8'h00;
      ack_in    <= step_last && word.ak && |(sampled & i2cbs_pkg::TopBit);
    end
  end

  a_mid_beat_busy : assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> busy)
    else $error("non-final beat pending while sequencer idle");

  a_read_byte_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && read_byte != 8'h00 |-> last)
    else $error("read byte shown before final beat");

  a_cnt_idle : assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == '0)
    else $error("bit counter left running after program end");

  a_ack_clock_low : assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_in |-> !scl)
    else $error("ack presented with clock high");

endmodule

[tb/tb_i2c_master_bit_sequencer.sv]
// Self-checking testbench for i2c_master_bit_sequencer: predicts every SCL/SDA
// pin write of each accepted command and checks the output beats in order.
// Depends on i2cbs_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

typedef struct packed {
  logic       scl;
  logic       sda;
  logic [7:0] read_byte;
  logic       ack_in;
  logic       last;
} pin_write_t;

class pin_write_board;
  logic       line_scl;
  logic       line_sda;
  pin_write_t expected_writes[$];
  int         errors;
  int         checked;
  int         commands_seen[8];

  function new();
    line_scl = 1'b1;
    line_sda = 1'b1;
    errors   = 0;
    checked  = 0;
    foreach (commands_seen[i]) commands_seen[i] = 0;
  endfunction

  function void set_line(i2cbs_pkg::pin_t pin, logic level);
    pin_write_t w;
    if (pin == i2cbs_pkg::PIN_SCL) line_scl = level;
    else line_sda = level;
    w = '0;
    w.scl = line_scl;
    w.sda = line_sda;
    expected_writes.push_back(w);
  endfunction

  // Expand one accepted command into the pin writes it makes.
  function void note_command(logic [2:0] cmd, logic [7:0] wbyte, logic ack,
                             logic [7:0] bus_bits);
    int tail;
    commands_seen[cmd]++;
    case (i2cbs_pkg::cmd_t'(cmd))
      i2cbs_pkg::CMD_START: begin
        set_line(i2cbs_pkg::PIN_SDA, 1'b1);
        set_line(i2cbs_pkg::PIN_SCL, 1'b1);
        set_line(i2cbs_pkg::PIN_SDA, 1'b0);
        set_line(i2cbs_pkg::PIN_SCL, 1'b0);
      end
      i2cbs_pkg::CMD_STOP: begin
        set_line(i2cbs_pkg::PIN_SDA, 1'b0);
        set_line(i2cbs_pkg::PIN_SCL, 1'b1);
        set_line(i2cbs_pkg::PIN_SDA, 1'b1);
      end
      i2cbs_pkg::CMD_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          set_line(i2cbs_pkg::PIN_SDA, wbyte[i]);
          set_line(i2cbs_pkg::PIN_SCL, 1'b1);
          set_line(i2cbs_pkg::PIN_SCL, 1'b0);
        end
      end
      i2cbs_pkg::CMD_READ: begin
        set_line(i2cbs_pkg::PIN_SDA, 1'b1);
        repeat (8) begin
          set_line(i2cbs_pkg::PIN_SCL, 1'b1);
          set_line(i2cbs_pkg::PIN_SCL, 1'b0);
        end
      end
      i2cbs_pkg::CMD_SEND_ACK: begin
        set_line(i2cbs_pkg::PIN_SDA, ack);
        set_line(i2cbs_pkg::PIN_SCL, 1'b1);
        set_line(i2cbs_pkg::PIN_SCL, 1'b0);
      end
      i2cbs_pkg::CMD_RECV_ACK: begin
        set_line(i2cbs_pkg::PIN_SDA, 1'b1);
        set_line(i2cbs_pkg::PIN_SCL, 1'b1);
        set_line(i2cbs_pkg::PIN_SCL, 1'b0);
      end
      default: return;
    endcase
    tail = expected_writes.size() - 1;
    expected_writes[tail].last = 1'b1;
    // The DUT latches the bus bits whole on acceptance, so the read byte equals them.
    if (cmd == i2cbs_pkg::CMD_READ) expected_writes[tail].read_byte = bus_bits;
    if (cmd == i2cbs_pkg::CMD_RECV_ACK) expected_writes[tail].ack_in = bus_bits[7];
  endfunction

  function void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: beat %0d field %s expected %0h actual %0h",
               $time, checked, field, want, got);
    end
  endfunction

  function void check_pin_write(pin_write_t got);
    pin_write_t want;
    if (expected_writes.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none actual scl=%0b sda=%0b last=%0b",
               $time, got.scl, got.sda, got.last);
      return;
    end
    want = expected_writes.pop_front();
    compare_field("scl", 8'(want.scl), 8'(got.scl));
    compare_field("sda", 8'(want.sda), 8'(got.sda));
    compare_field("read_byte", want.read_byte, got.read_byte);
    compare_field("ack_in", 8'(want.ack_in), 8'(got.ack_in));
    compare_field("last", 8'(want.last), 8'(got.last));
    checked++;
  endfunction
endclass

module tb_i2c_master_bit_sequencer;

  localparam int HangLimit = 4000;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] command = 3'd0;
  logic [7:0] write_byte = 8'd0;
  logic       ack_bit = 1'b0;
  logic [7:0] bus_sda_bits = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl;
  logic       sda;
  logic [7:0] read_byte;
  logic       ack_in;
  logic       last;

  pin_write_board board;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             commands_sent = 0;
  int             quiet_cycles = 0;

  i2c_master_bit_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .write_byte   (write_byte),
    .ack_bit      (ack_bit),
    .bus_sda_bits (bus_sda_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl          (scl),
    .sda          (sda),
    .read_byte    (read_byte),
    .ack_in       (ack_in),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sample both handshakes on pre-edge values; also watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_valid && !in_stall)
        board.note_command(command, write_byte, ack_bit, bus_sda_bits);
      if (out_valid && !out_stall)
        board.check_pin_write('{scl, sda, read_byte, ack_in, last});
      if (quiet_cycles >= HangLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, HangLimit);
        $display("tb_i2c_master_bit_sequencer failed");
        $finish;
      end
    end
  end

  // Present one command beat and hold it until taken.
  task automatic issue(logic [2:0] cmd, logic [7:0] wbyte, logic ack,
                       logic [7:0] bus_bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    write_byte   <= wbyte;
    ack_bit      <= ack;
    bus_sda_bits <= bus_bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd < i2cbs_pkg::CMD_RSVD6) commands_sent++;
  endtask

  task automatic issue_random(i2cbs_pkg::cmd_t cmd);
    issue(cmd, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // A well-formed transfer: start, address, ack, data phase, then a stop most times.
  task automatic run_transfer();
    logic [7:0] addr;
    int         nbytes;
    addr   = 8'($urandom);
    nbytes = $urandom_range(1, 4);
    issue_random(i2cbs_pkg::CMD_START);
    issue(i2cbs_pkg::CMD_WRITE, addr, 1'($urandom), 8'($urandom));
    issue_random(i2cbs_pkg::CMD_RECV_ACK);
    repeat (nbytes) begin
      if (addr[0]) begin
        issue_random(i2cbs_pkg::CMD_READ);
        issue_random(i2cbs_pkg::CMD_SEND_ACK);
      end else begin
        issue_random(i2cbs_pkg::CMD_WRITE);
        issue_random(i2cbs_pkg::CMD_RECV_ACK);
      end
    end
    // Drop the stop now and then so the next start is a repeated start.
    if ($urandom_range(9) != 0) issue_random(i2cbs_pkg::CMD_STOP);
  endtask

  initial begin
    int target;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of each field and every command, reserved codes too.
    issue(i2cbs_pkg::CMD_STOP,     8'h00, 1'b0, 8'h00);
    issue(i2cbs_pkg::CMD_START,    8'hFF, 1'b1, 8'hFF);
    issue(i2cbs_pkg::CMD_WRITE,    8'h00, 1'b0, 8'hFF);
    issue(i2cbs_pkg::CMD_WRITE,    8'hFF, 1'b1, 8'h00);
    issue(i2cbs_pkg::CMD_WRITE,    8'hA5, 1'b0, 8'h5A);
    issue(i2cbs_pkg::CMD_RECV_ACK, 8'h00, 1'b0, 8'h80);
    issue(i2cbs_pkg::CMD_RECV_ACK, 8'hFF, 1'b1, 8'h7F);
    issue(i2cbs_pkg::CMD_READ,     8'hFF, 1'b1, 8'h00);
    issue(i2cbs_pkg::CMD_READ,     8'h00, 1'b0, 8'hFF);
    issue(i2cbs_pkg::CMD_READ,     8'h3C, 1'b1, 8'h5A);
    issue(i2cbs_pkg::CMD_SEND_ACK, 8'hFF, 1'b0, 8'hFF);
    issue(i2cbs_pkg::CMD_SEND_ACK, 8'h00, 1'b1, 8'h00);
    issue(i2cbs_pkg::CMD_RSVD6,    8'hFF, 1'b1, 8'hFF);
    issue(i2cbs_pkg::CMD_STOP,     8'h55, 1'b1, 8'hAA);
    issue(i2cbs_pkg::CMD_RSVD7,    8'h00, 1'b0, 8'h00);
    issue(i2cbs_pkg::CMD_STOP,     8'hAA, 1'b0, 8'h55);
    issue(i2cbs_pkg::CMD_START,    8'h00, 1'b0, 8'h00);
    issue(i2cbs_pkg::CMD_START,    8'h81, 1'b1, 8'h18);

    // Random: mostly real transfers, some loose commands, over four idle mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      target = commands_sent + 55;
      while (commands_sent < target) begin
        if ($urandom_range(4) == 0)
          issue_random(i2cbs_pkg::cmd_t'($urandom_range(0, 7)));
        else run_transfer();
      end
    end
    in_valid <= 1'b0;

    while (board.expected_writes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Checked %0d pin-write beats from %0d commands:", board.checked, commands_sent);
    $display("start %0d, stop %0d, write %0d, read %0d, ack out %0d, ack in %0d, reserved %0d",
             board.commands_seen[i2cbs_pkg::CMD_START],
             board.commands_seen[i2cbs_pkg::CMD_STOP],
             board.commands_seen[i2cbs_pkg::CMD_WRITE],
             board.commands_seen[i2cbs_pkg::CMD_READ],
             board.commands_seen[i2cbs_pkg::CMD_SEND_ACK],
             board.commands_seen[i2cbs_pkg::CMD_RECV_ACK],
             board.commands_seen[i2cbs_pkg::CMD_RSVD6] +
             board.commands_seen[i2cbs_pkg::CMD_RSVD7]);
    if (board.errors == 0 && board.expected_writes.size() == 0)
      $display("tb_i2c_master_bit_sequencer passed");
    else
      $display("tb_i2c_master_bit_sequencer failed");
    $finish;
  end

endmodule
